/* design/dpp_pkg.sv */
// Shared types and codes for the dual-pivot partition block.
// Holds the request/response payload structs, status and register codes,
// and the command/status structs between controller and datapath.
package dpp_pkg;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 10;
   localparam int BOUND_W = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 10;

   // Request function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_PIVOT = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_BAD_READ  = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_PIVOT  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SECOND_PIVOT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SIGNED_CMP   = 2'd2;

   typedef struct packed {
      logic               func;
      logic [VALUE_W-1:0] element_value;
      logic               is_last;
      logic [INDEX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic [BOUND_W-1:0] first_boundary;
      logic [BOUND_W-1:0] second_boundary;
      logic [1:0]         status;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic check;
      logic pivot_set;
      logic scan_rd;
      logic scan_cmp;
      logic scan_wr;
      logic scan_end;
      logic swap_rd;
      logic swap_w1;
      logic swap_w2;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_read;
      logic req_last;
      logic req_full;
      logic pivot_bad;
      logic take_less;
      logic scan_last;
      logic phase2;
      logic scan2_empty;
      logic out_free;
   } stat_type;

endpackage

/* design/dpp_datapath.sv */
// Datapath of the dual-pivot partition block: element store, scan and
// swap registers, configuration registers and the response register.
// Depends on dpp_pkg; driven by dpp_ctrl through dpp_pkg::cmd_type.
module dpp_datapath #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int STORE_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [dpp_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dpp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  dpp_pkg::req_type                req_data,
   input  dpp_pkg::cmd_type                cmd,
   output dpp_pkg::stat_type               stat,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output dpp_pkg::rsp_type                rsp_data
);
   import dpp_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int EW = ELEMENT_WIDTH;

   function automatic logic elem_less(input logic [ELEMENT_WIDTH-1:0] x,
                                      input logic [ELEMENT_WIDTH-1:0] y,
                                      input logic sgn);
      logic [ELEMENT_WIDTH-1:0] flip;
      flip = ELEMENT_WIDTH'(sgn) << (ELEMENT_WIDTH - 1);
      return (x ^ flip) < (y ^ flip);
   endfunction

   logic [EW-1:0]      store_mem [STORE_DEPTH];
   logic [EW-1:0]      rd_a_ff, rd_b_ff;

   logic [CW-1:0]      count_ff, count_in;
   logic               closed_ff, closed_in;
   logic [AW-1:0]      low_b_ff, low_b_in;
   logic [AW-1:0]      high_b_ff, high_b_in;
   logic [INDEX_W-1:0] fp_ff, fp_in;
   logic [INDEX_W-1:0] sp_ff, sp_in;
   logic               sgn_ff, sgn_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               phase_ff, phase_in;

   logic [AW-1:0]      lo_ff, lo_in;
   logic [AW-1:0]      hi_ff, hi_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [AW-1:0]      fill_ff, fill_in;
   logic [EW-1:0]      plo_ff, plo_in;
   logic [EW-1:0]      phi_ff, phi_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [1:0]         st_ff, st_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CW-1:0]      eff_count;
   logic               load_full;
   logic               read_ok;
   logic               pivot_bad;
   logic [EW-1:0]      cur_pivot;
   logic               take_less;
   logic [AW-1:0]      target;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [EW-1:0]      wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr_a, rd_addr_b;

   always_comb begin
      // A closed batch restarts empty on the next load
      eff_count = closed_ff ? '0 : count_ff;
      load_full = (eff_count == CW'(STORE_DEPTH));
      read_ok   = CMPW'(req_data.read_index) < CMPW'(count_ff);
      pivot_bad = (CMPW'(fp_ff) >= CMPW'(count_ff)) || (CMPW'(sp_ff) >= CMPW'(count_ff))
                  || (fp_ff == sp_ff);
      cur_pivot = phase_ff ? phi_ff : plo_ff;
      take_less = elem_less(rd_a_ff, cur_pivot, sgn_ff);
      target    = phase_ff ? hi_ff : lo_ff;
   end

   // Store port selection
   always_comb begin
      wr_en = 1'b0;
      wr_addr = fill_ff;
      wr_data = rd_a_ff;
      rd_en = 1'b0;
      rd_addr_a = i_ff;
      rd_addr_b = fill_ff;
      if (cmd.take) begin
         if (req_data.func == FUNC_READ) begin
            rd_en = 1'b1;
            rd_addr_a = AW'(req_data.read_index);
         end else begin
            wr_en = !load_full;
            wr_addr = AW'(eff_count);
            wr_data = EW'(req_data.element_value);
         end
      end
      if (cmd.check) begin
         rd_en = 1'b1;
         rd_addr_a = AW'(fp_ff);
         rd_addr_b = AW'(sp_ff);
      end
      if (cmd.scan_rd) begin
         rd_en = 1'b1;
      end
      if (cmd.scan_cmp) begin
         wr_en = take_less;
      end
      if (cmd.scan_wr) begin
         wr_en = 1'b1;
         wr_addr = i_ff;
         wr_data = rd_b_ff;
      end
      if (cmd.swap_rd) begin
         rd_en = 1'b1;
         rd_addr_a = fill_ff;
         rd_addr_b = target;
      end
      if (cmd.swap_w1) begin
         wr_en = 1'b1;
         wr_data = rd_b_ff;
      end
      if (cmd.swap_w2) begin
         wr_en = 1'b1;
         wr_addr = target;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= store_mem[rd_addr_a];
         rd_b_ff <= store_mem[rd_addr_b];
      end
   end

   always_comb begin
      count_in = count_ff;
      closed_in = closed_ff;
      low_b_in = low_b_ff;
      high_b_in = high_b_ff;
      fp_in = fp_ff;
      sp_in = sp_ff;
      sgn_in = sgn_ff;
      phase_in = phase_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      i_in = i_ff;
      fill_in = fill_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      rd_ok_in = rd_ok_ff;
      st_in = st_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_wr_en) begin
         case (csr_addr)
            CSR_FIRST_PIVOT:  fp_in = csr_wdata;
            CSR_SECOND_PIVOT: sp_in = csr_wdata;
            CSR_SIGNED_CMP:   sgn_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.take) begin
         if (req_data.func == FUNC_READ) begin
            rd_ok_in = read_ok;
            st_in = read_ok ? ST_OK : ST_BAD_READ;
         end else begin
            rd_ok_in = 1'b0;
            closed_in = req_data.is_last;
            count_in = load_full ? eff_count : eff_count + CW'(1);
            st_in = load_full ? ST_FULL : ST_OK;
         end
      end

      if (cmd.check && pivot_bad) begin
         low_b_in = '0;
         high_b_in = '0;
         st_in = ST_BAD_PIVOT;
      end

      // Order the pivots; rd_a holds the first, rd_b the second
      if (cmd.pivot_set) begin
         if (elem_less(rd_b_ff, rd_a_ff, sgn_ff)) begin
            lo_in = AW'(sp_ff);
            hi_in = AW'(fp_ff);
            plo_in = rd_b_ff;
            phi_in = rd_a_ff;
         end else begin
            lo_in = AW'(fp_ff);
            hi_in = AW'(sp_ff);
            plo_in = rd_a_ff;
            phi_in = rd_b_ff;
         end
         i_in = '0;
         fill_in = '0;
         phase_in = 1'b0;
      end

      // Track pivot positions as the swap moves the element at fill to i
      if (cmd.scan_cmp) begin
         if (take_less) begin
            fill_in = fill_ff + AW'(1);
            if (!phase_ff && lo_ff == fill_ff) begin
               lo_in = i_ff;
            end
            if (hi_ff == fill_ff) begin
               hi_in = i_ff;
            end
         end else begin
            i_in = i_ff + AW'(1);
         end
      end

      if (cmd.scan_wr) begin
         i_in = i_ff + AW'(1);
      end

      if (cmd.scan_end && !phase_ff) begin
         if (hi_ff == fill_ff) begin
            hi_in = lo_ff;
         end else if (hi_ff == lo_ff) begin
            hi_in = fill_ff;
         end
      end

      if (cmd.swap_w2) begin
         if (!phase_ff) begin
            low_b_in = fill_ff;
            fill_in = fill_ff + AW'(1);
            i_in = fill_ff + AW'(1);
            phase_in = 1'b1;
         end else begin
            high_b_in = fill_ff;
         end
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in.read_value = rd_ok_ff ? VALUE_W'(rd_a_ff) : '0;
         rsp_in.first_boundary = BOUND_W'(low_b_ff);
         rsp_in.second_boundary = BOUND_W'(high_b_ff);
         rsp_in.status = st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         closed_ff <= 1'b0;
         low_b_ff <= '0;
         high_b_ff <= '0;
         fp_ff <= '0;
         sp_ff <= '0;
         sgn_ff <= 1'b0;
         phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         closed_ff <= closed_in;
         low_b_ff <= low_b_in;
         high_b_ff <= high_b_in;
         fp_ff <= fp_in;
         sp_ff <= sp_in;
         sgn_ff <= sgn_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      i_ff <= i_in;
      fill_ff <= fill_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      rd_ok_ff <= rd_ok_in;
      st_ff <= st_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      stat.req_read = (req_data.func == FUNC_READ);
      stat.req_last = req_data.is_last;
      stat.req_full = load_full;
      stat.pivot_bad = pivot_bad;
      stat.take_less = take_less;
      stat.scan_last = (CW'(i_ff) + CW'(1)) == count_ff;
      stat.phase2 = phase_ff;
      stat.scan2_empty = (CW'(fill_ff) + CW'(2)) > count_ff;
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

/* design/dpp_ctrl.sv */
// Controller of the dual-pivot partition block: sequences loads, reads,
// the two partition scans and the pivot swaps. Depends on dpp_pkg.
module dpp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dpp_pkg::stat_type stat,
   output dpp_pkg::cmd_type  cmd
);
   import dpp_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CHECK    = 4'd1;
   localparam logic [3:0] S_PIVOT    = 4'd2;
   localparam logic [3:0] S_SCAN_RD  = 4'd3;
   localparam logic [3:0] S_SCAN_CMP = 4'd4;
   localparam logic [3:0] S_SCAN_WR  = 4'd5;
   localparam logic [3:0] S_SCAN_END = 4'd6;
   localparam logic [3:0] S_SWAP_RD  = 4'd7;
   localparam logic [3:0] S_SWAP_W1  = 4'd8;
   localparam logic [3:0] S_SWAP_W2  = 4'd9;
   localparam logic [3:0] S_RESP     = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.take = req_valid;
            if (req_valid) begin
               if (stat.req_read) begin
                  state_in = S_RESP;
               end else if (stat.req_last) begin
                  state_in = S_CHECK;
               end else if (stat.req_full) begin
                  state_in = S_RESP;
               end
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in = stat.pivot_bad ? S_RESP : S_PIVOT;
         end
         S_PIVOT: begin
            cmd.pivot_set = 1'b1;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            if (stat.take_less) begin
               state_in = S_SCAN_WR;
            end else begin
               state_in = stat.scan_last ? S_SCAN_END : S_SCAN_RD;
            end
         end
         S_SCAN_WR: begin
            cmd.scan_wr = 1'b1;
            state_in = stat.scan_last ? S_SCAN_END : S_SCAN_RD;
         end
         S_SCAN_END: begin
            cmd.scan_end = 1'b1;
            state_in = S_SWAP_RD;
         end
         S_SWAP_RD: begin
            cmd.swap_rd = 1'b1;
            state_in = S_SWAP_W1;
         end
         S_SWAP_W1: begin
            cmd.swap_w1 = 1'b1;
            state_in = S_SWAP_W2;
         end
         S_SWAP_W2: begin
            cmd.swap_w2 = 1'b1;
            if (stat.phase2) begin
               state_in = S_RESP;
            end else if (stat.scan2_empty) begin
               // nothing to scan above the first boundary: place the larger pivot
               state_in = S_SWAP_RD;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_RESP: begin
            cmd.rsp_load = stat.out_free;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/dual_pivot_partition.sv */
// Dual-pivot three-way partition block.
// Channels: req (valid/ready, dpp_pkg::req_type) carries loads and reads;
// rsp (valid/ready, dpp_pkg::rsp_type) returns one result per read, per
// load that is last or hits a full store; a plain loaded element returns
// nothing. csr is a write-only port for both pivot indexes and the compare
// mode; write it only while the block is idle.
// Sequence: a load that returns nothing leaves the controller idle. A
// read or a full-store load goes straight to the result state; a bad
// pivot pair passes the check first. A good last load runs the check,
// orders the pivots, scans and swaps for the smaller pivot, then scans
// (skipped when nothing lies above the first boundary) and swaps for the
// larger one. In all, s = 2n - b - 1 elements are compared (n the element
// count, b the first boundary); a moved element needs a further write
// state, since the store has one write port.
// The result register lets the next item be taken while a result waits;
// a further result waits in its final state until rsp_ready frees the slot.
// Reset empties the store (count zero), clears both boundaries, the
// configuration and any pending result. Store contents are not cleared;
// reads are limited to positions below the element count.
module dual_pivot_partition #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int STORE_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  dpp_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dpp_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [dpp_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dpp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dpp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   dpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dpp_datapath #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .STORE_DEPTH   (STORE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A waiting result is never overwritten
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || rsp_ready))
      else $error("response register loaded while occupied");

   // An accepted read blocks new transactions until its result is placed
   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.func == FUNC_READ) |=> !req_ready)
      else $error("transaction accepted before read result placed");

   // No transaction is accepted while the partition scans the store
   a_scan_exclusive: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_cmp || cmd.scan_wr || cmd.swap_w1 || cmd.swap_w2) |-> !req_ready)
      else $error("transaction accepted during partition");

endmodule
